// ----- hw/rtl/okl_pkg.sv -----
package okl_pkg;

   localparam logic [1:0] KIND_SEARCH = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] key_id;
      logic [63:0]        entry_payload;
      logic [6:0]         position;
   } okl_req_type;

   typedef struct packed {
      logic        status;
      logic        found;
      logic [6:0]  found_position;
      logic [63:0] found_payload;
      logic [6:0]  entry_count;
   } okl_rsp_type;

endpackage

// ----- hw/rtl/ordered_keyed_list_table_core.sv -----
// Search and delete scan entries from the head, one entry per cycle, up to the first match;
// a miss is answered once all entries are compared. A delete hit then moves each later
// entry up by one to close the gap. Insert moves the entries from its position on down
// by one from the tail, then writes the new one; a rejected request never leaves idle.
// One item at a time: busy stays high until the result strobe; results cannot be stalled.
// Reset (synchronous) empties the list; stored entries are not cleared.
module ordered_keyed_list_table_core #(
   parameter int DEPTH         = 64,
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  okl_pkg::okl_req_type req_data,
   output logic                 rsp_valid,
   output okl_pkg::okl_rsp_type rsp_data
);
   import okl_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = ((CW > 7) ? CW : 7) + 1;
   localparam int EW = 32 + PAYLOAD_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_SHIFT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   okl_req_type           req_ff, req_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [XW-1:0]         scan_ff, scan_in;
   logic [CW-1:0]         rem_ff, rem_in;
   logic [AW-1:0]         shaddr_ff, shaddr_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_idx_ff, pend_idx_in;
   logic [AW-1:0]         hit_idx_ff, hit_idx_in;
   logic [PAYLOAD_WIDTH-1:0] hit_pay_ff, hit_pay_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   okl_rsp_type           rsp_ff, rsp_in;

   logic [EW-1:0]         entry_mem [DEPTH];
   logic [EW-1:0]         rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;

   logic [31:0]              rd_key;
   logic [PAYLOAD_WIDTH-1:0] rd_pay;
   logic [XW-1:0]            pos_x, cnt_x;
   logic                     ins_ok;
   logic                     key_hit;

   assign rd_key  = rd_data_ff[EW-1:PAYLOAD_WIDTH];
   assign rd_pay  = rd_data_ff[PAYLOAD_WIDTH-1:0];
   assign key_hit = pend_ff && (rd_key == req_ff.key_id);

   assign pos_x  = XW'(req_data.position);
   assign cnt_x  = XW'(count_ff);
   assign ins_ok = (count_ff < CW'(DEPTH)) && (pos_x != '0) && (pos_x <= cnt_x + XW'(1));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      rem_in       = rem_ff;
      shaddr_in    = shaddr_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      hit_idx_in   = hit_idx_ff;
      hit_pay_in   = hit_pay_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = scan_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = pend_idx_ff;
      wr_data      = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               case (req_data.kind)
                  KIND_SEARCH, KIND_DELETE: begin
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
                  KIND_INSERT: begin
                     if (ins_ok) begin
                        rem_in    = count_ff - CW'(req_data.position) + CW'(1);
                        shaddr_in = AW'(count_ff - CW'(1));
                        state_in  = S_SHIFT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '{STATUS_ERR, 1'b0, 7'd0, 64'd0, 7'(count_ff)};
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{STATUS_ERR, 1'b0, 7'd0, 64'd0, 7'(count_ff)};
                  end
               endcase
            end
         end

         S_SCAN: begin
            // Reads go out one per cycle; each compare sees the entry held in the registered read data.
            rd_addr     = scan_ff[AW-1:0];
            pend_in     = scan_ff < cnt_x;
            pend_idx_in = scan_ff[AW-1:0];
            scan_in     = scan_ff + XW'(1);
            if (key_hit) begin
               pend_in = 1'b0;
               if (req_ff.kind == KIND_DELETE) begin
                  hit_idx_in = pend_idx_ff;
                  hit_pay_in = rd_pay;
                  rem_in     = count_ff - CW'(1) - CW'(pend_idx_ff);
                  shaddr_in  = pend_idx_ff + AW'(1);
                  state_in   = S_SHIFT;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{STATUS_OK, 1'b1, 7'(pend_idx_ff) + 7'd1,
                                   64'(rd_pay), 7'(count_ff)};
                  state_in     = S_IDLE;
               end
            end else if (!pend_ff && !(scan_ff < cnt_x)) begin
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = '{STATUS_ERR, 1'b0, 7'd0, 64'd0, 7'(count_ff)};
               state_in     = S_IDLE;
            end
         end

         S_SHIFT: begin
            // Insert walks down from the tail, delete walks up from the hole, so a
            // read never targets the entry written in the same cycle.
            rd_addr     = shaddr_ff;
            pend_in     = rem_ff != '0;
            pend_idx_in = shaddr_ff;
            if (rem_ff != '0) begin
               rem_in    = rem_ff - CW'(1);
               shaddr_in = (req_ff.kind == KIND_INSERT) ? shaddr_ff - AW'(1)
                                                        : shaddr_ff + AW'(1);
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = (req_ff.kind == KIND_INSERT) ? pend_idx_ff + AW'(1)
                                                      : pend_idx_ff - AW'(1);
               wr_data = rd_data_ff;
            end else if (rem_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (req_ff.kind == KIND_INSERT) begin
                  wr_en    = 1'b1;
                  wr_addr  = AW'(req_ff.position - 7'd1);
                  wr_data  = {req_ff.key_id, req_ff.entry_payload[PAYLOAD_WIDTH-1:0]};
                  count_in = count_ff + CW'(1);
                  rsp_in   = '{STATUS_OK, 1'b0, 7'd0, 64'd0, 7'(count_in)};
               end else begin
                  count_in = count_ff - CW'(1);
                  rsp_in   = '{STATUS_OK, 1'b1, 7'(hit_idx_ff) + 7'd1,
                               64'(hit_pay_ff), 7'(count_in)};
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_ff     <= scan_in;
      rem_ff      <= rem_in;
      shaddr_ff   <= shaddr_in;
      pend_idx_ff <= pend_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_pay_ff  <= hit_pay_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/okl_checker.sv -----
module okl_checker #(
   parameter int DEPTH = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input okl_pkg::okl_req_type req_data,
   input logic                 rsp_valid,
   input okl_pkg::okl_rsp_type rsp_data
);
   import okl_pkg::*;

   // An accepted item is either still in work or answered on the next cycle.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted item neither in work nor answered");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.entry_count) <= 32'(DEPTH)))
      else $error("entry count above depth");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |->
         (rsp_data.status == STATUS_OK && rsp_data.found_position != 7'd0))
      else $error("match reported without ok status or position");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         (rsp_data.found_position == 7'd0 && rsp_data.found_payload == 64'd0))
      else $error("miss reports nonzero position or payload");

   // A result only shows once the block has gone idle again.
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while block still busy");

endmodule

bind ordered_keyed_list_table_core okl_checker #(.DEPTH(DEPTH)) u_okl_checker (.*);

// ----- sim/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import okl_pkg::*;

   localparam int LIST_DEPTH  = 64;
   localparam int PAY_W       = 64;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int TAIL_CYCLES = 2 * LIST_DEPTH + 20;
   localparam int RANDOM_ITEMS = 930;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [63:0] PAY_MASK = {64{1'b1}} >> (64 - PAY_W);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   okl_req_type req_data = '0;
   logic        rsp_valid;
   okl_rsp_type rsp_data;

   // Shadow copy of the list, kept in step with every accepted item.
   logic signed [31:0] key_mem [LIST_DEPTH];
   logic [63:0]        pay_mem [LIST_DEPTH];
   int                 entry_total = 0;

   okl_rsp_type expected_rsps [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   int          no_idle_left = 0;

   ordered_keyed_list_table_core #(
      .DEPTH         (LIST_DEPTH),
      .PAYLOAD_WIDTH (PAY_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ordered_keyed_list_table_core regression: fail");
         $finish;
      end
   end

   function automatic int find_first_key(logic signed [31:0] key);
      int i;
      for (i = 0; i < entry_total; i++) begin
         if (key_mem[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic okl_rsp_type predict_list(okl_req_type r);
      okl_rsp_type res;
      int idx;
      int i;
      int pos;
      res = '0;
      res.status = STATUS_ERR;
      pos = r.position;
      case (r.kind)
         KIND_SEARCH: begin
            idx = find_first_key(r.key_id);
            if (idx >= 0) begin
               res.status = STATUS_OK;
               res.found = 1'b1;
               res.found_position = 7'(idx + 1);
               res.found_payload = pay_mem[idx];
            end
         end
         KIND_INSERT: begin
            if (entry_total < LIST_DEPTH && pos >= 1 && pos <= entry_total + 1) begin
               for (i = entry_total; i >= pos; i--) begin
                  key_mem[i] = key_mem[i - 1];
                  pay_mem[i] = pay_mem[i - 1];
               end
               key_mem[pos - 1] = r.key_id;
               pay_mem[pos - 1] = r.entry_payload & PAY_MASK;
               entry_total++;
               res.status = STATUS_OK;
            end
         end
         KIND_DELETE: begin
            idx = find_first_key(r.key_id);
            if (idx >= 0) begin
               res.status = STATUS_OK;
               res.found = 1'b1;
               res.found_position = 7'(idx + 1);
               res.found_payload = pay_mem[idx];
               for (i = idx; i + 1 < entry_total; i++) begin
                  key_mem[i] = key_mem[i + 1];
                  pay_mem[i] = pay_mem[i + 1];
               end
               entry_total--;
            end
         end
         default: ;
      endcase
      res.entry_count = 7'(entry_total);
      return res;
   endfunction

   function automatic okl_req_type make_req(logic [1:0] kind, logic signed [31:0] key,
                                            logic [63:0] payload, logic [6:0] pos);
      okl_req_type r;
      r.kind = kind;
      r.key_id = key;
      r.entry_payload = payload;
      r.position = pos;
      return r;
   endfunction

   // Called at a rising edge. Leaves start high after the item is taken, so the
   // caller either sends the next item or lowers start in the same step.
   task automatic send_item(okl_req_type r);
      int gap;
      if (no_idle_left > 0) begin
         gap = 0;
         no_idle_left--;
      end else begin
         if ($urandom_range(0, 29) == 0) no_idle_left = $urandom_range(10, 40);
         gap = $urandom_range(0, 18);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      expected_rsps.push_back(predict_list(r));
   endtask

   task automatic wait_all_done();
      start <= 1'b0;
      do @(posedge clock); while (expected_rsps.size() > 0);
   endtask

   always @(posedge clock) begin
      okl_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("result arrived with no item outstanding: %h", rsp_data);
            fail_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_data.found);
               fail_count++;
            end
            if (rsp_data.found_position !== want.found_position) begin
               $error("found_position: expected %0d, got %0d",
                      want.found_position, rsp_data.found_position);
               fail_count++;
            end
            if (rsp_data.found_payload !== want.found_payload) begin
               $error("found_payload: expected %h, got %h",
                      want.found_payload, rsp_data.found_payload);
               fail_count++;
            end
            if (rsp_data.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_data.entry_count);
               fail_count++;
            end
         end
      end
   end

   // Short hand-built sequence: empty-list misses, rejected positions, key
   // extremes, duplicate keys, deletes at head, middle and tail.
   task automatic test_directed();
      send_item(make_req(KIND_SEARCH, 32'sd5, 64'h0, 7'd0));
      send_item(make_req(KIND_DELETE, 32'sd5, 64'h0, 7'd0));
      send_item(make_req(KIND_INSERT, 32'sd1, 64'h1, 7'd0));
      send_item(make_req(KIND_INSERT, 32'sd1, 64'h1, 7'd2));
      send_item(make_req(KIND_INSERT, 32'sd1, 64'h1, 7'd127));
      send_item(make_req(KIND_INSERT, 32'sh8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1));
      send_item(make_req(KIND_INSERT, 32'sh7FFF_FFFF, 64'h0, 7'd2));
      send_item(make_req(KIND_INSERT, -32'sd1, 64'hA5A5_A5A5_A5A5_A5A5, 7'd1));
      send_item(make_req(KIND_INSERT, 32'sd0, 64'h5A5A_5A5A_5A5A_5A5A, 7'd2));
      send_item(make_req(KIND_INSERT, 32'sd0, 64'h1234_5678_9ABC_DEF0, 7'd5));
      send_item(make_req(KIND_INSERT, 32'sd9, 64'h9, 7'd7));
      send_item(make_req(KIND_SEARCH, 32'sd0, 64'h0, 7'd0));
      send_item(make_req(KIND_SEARCH, 32'sh7FFF_FFFF, 64'h0, 7'd0));
      send_item(make_req(KIND_SEARCH, 32'sh8000_0000, 64'h0, 7'd0));
      send_item(make_req(KIND_SEARCH, 32'sd12345, 64'h0, 7'd0));
      send_item(make_req(KIND_DELETE, 32'sd0, 64'h0, 7'd0));
      send_item(make_req(KIND_SEARCH, 32'sd0, 64'h0, 7'd0));
      send_item(make_req(KIND_DELETE, -32'sd1, 64'h0, 7'd0));
      send_item(make_req(KIND_DELETE, 32'sd0, 64'h0, 7'd0));
      send_item(make_req(KIND_UNUSED, -32'sd1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127));
      send_item(make_req(KIND_DELETE, 32'sh8000_0000, 64'h0, 7'd0));
      send_item(make_req(KIND_DELETE, 32'sh7FFF_FFFF, 64'h0, 7'd0));
      send_item(make_req(KIND_DELETE, 32'sh7FFF_FFFF, 64'h0, 7'd0));
   endtask

   function automatic logic signed [31:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (entry_total > 0 && roll < 55) return key_mem[$urandom_range(0, entry_total - 1)];
      if (roll < 75) return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      return $signed($urandom);
   endfunction

   // The list swings between growing until it is full (and stays full for a
   // while, so inserts are refused) and shrinking until it is empty.
   task automatic test_random_traffic(int n_items);
      okl_req_type r;
      int          i;
      int          roll;
      bit          growing;
      growing = 1'b1;
      for (i = 0; i < n_items; i++) begin
         if (growing && entry_total == LIST_DEPTH && $urandom_range(0, 7) == 0)
            growing = 1'b0;
         else if (!growing && entry_total == 0 && $urandom_range(0, 3) == 0)
            growing = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll >= 95) r.kind = KIND_UNUSED;
         else if (growing) r.kind = (roll < 60) ? KIND_INSERT : (roll < 78) ? KIND_SEARCH
                                                                           : KIND_DELETE;
         else r.kind = (roll < 15) ? KIND_INSERT : (roll < 40) ? KIND_SEARCH : KIND_DELETE;
         r.key_id = pick_key();
         r.entry_payload = {$urandom, $urandom};
         if ($urandom_range(0, 99) < 85) r.position = 7'($urandom_range(1, entry_total + 1));
         else r.position = 7'($urandom_range(0, 127));
         send_item(r);
         if (i % 200 == 199) wait_all_done();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_all_done();
      test_random_traffic(RANDOM_ITEMS);
      wait_all_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("ordered_keyed_list_table_core regression: pass");
      end else begin
         $display("ordered_keyed_list_table_core regression: fail");
      end
      $finish;
   end

endmodule
